FILE: sv/lps_pkg.sv
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types and constants of the light pattern sequencer.
// ----------------------------------------------------------------------------
package lps_pkg;

    // Default sizes
    localparam int NUM_STYLES_DEF  = 64;
    localparam int PATTERN_LEN_DEF = 64;

    // Field widths
    localparam int KIND_W   = 2;
    localparam int STYLE_W  = 6;
    localparam int POS_W    = 6;
    localparam int LETTER_W = 8;
    localparam int LEN_W    = 6;
    localparam int TIME_W   = 31;
    localparam int STEP_W   = 25;
    localparam int LEVEL_W  = 13;
    localparam int WHITE_W  = 15;

    // Divider: one iteration per step bit, divisor is a pattern length
    localparam int DIVR_W    = 7;
    localparam int DIV_ITER  = STEP_W;
    localparam int DIV_CNT_W = $clog2(DIV_ITER + 1);

    // Arithmetic constants
    localparam int                    STEP_MS     = 100;
    // ceil(2^33 / 25): floor(t / 100) = ((t >> 2) * STEP_RECIP) >> 33 for t < 2^31
    localparam logic [TIME_W-3:0]     STEP_RECIP  = 29'd343597384;
    localparam int                    STEP_SH     = 33;
    localparam logic [LETTER_W-1:0]   LETTER_DARK = 8'd97;
    localparam logic signed [LEVEL_W-1:0] FULL_LEVEL = 13'sd256;
    // ceil(2^16 / 3): exact floor(x / 3) for x below 2^15
    localparam logic [14:0]           RECIP3      = 15'd21846;
    localparam int                    RECIP3_SH   = 16;

    // Request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_LETTER = 2'd0,
        KIND_LENGTH = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_TIME   = 2'd3
    } t_kind;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP_CHK,
        ST_LEN_RD,
        ST_LEN_CHK,
        ST_MOD_DIV,
        ST_PAT_RD,
        ST_EMIT
    } t_state;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

FILE: sv/lps_ram.sv
// ----------------------------------------------------------------------------
// lps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/lps_div.sv
// ----------------------------------------------------------------------------
// lps_div
// Restoring divider, one quotient bit per cycle, giving step mod pattern
// length for the pattern index.
// ----------------------------------------------------------------------------
module lps_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lps_pkg::STEP_W-1:0]    i_dividend,
    input  logic [lps_pkg::DIVR_W-1:0]    i_divisor,
    output lps_pkg::t_div_stat            o_stat,
    output logic [lps_pkg::DIVR_W-1:0]    o_remainder
);

    import lps_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [STEP_W-1:0]     r_quo;
    logic [DIVR_W-1:0]     r_rem;
    logic [DIVR_W-1:0]     r_div;

    logic [DIVR_W:0]       trial;
    logic [DIVR_W:0]       diff;
    logic                  ge;
    logic [DIVR_W-1:0]     n_rem;

    // One iteration: shift in next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_quo[STEP_W-1]};
        diff  = trial - {1'b0, r_div};
        ge    = (trial >= {1'b0, r_div});
        n_rem = ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_ITER);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[STEP_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy  = r_busy;
    assign o_stat.done  = r_done;
    assign o_remainder  = r_rem;

    // A new division never starts over one in flight
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

endmodule

FILE: sv/light_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// light_pattern_sequencer
// Keeps a letter pattern and a length per light style and, on a time request
// that lands on a new 100 ms step, reports the brightness of every style in
// style order. Letter, length and clear requests are handled in idle and leave
// the state unchanged. A time request goes to a step check that compares its
// step (found by a reciprocal multiply at acceptance) with the last one; for
// a new step, each style then passes the length read and the length check,
// and for a non-zero length also the 25-iteration serial divider pass for
// step mod length and the pattern read, before the hand-off to the output
// register, which waits while the output side stalls. A result waits in the
// output register while the next style is worked on. Levels are signed Q.8
// (256 is normal); white is three times the level. Pattern letters live in
// one RAM and are undefined until written; lengths live in a small RAM with
// per-style valid bits, so reset and clear take effect at once.
// ----------------------------------------------------------------------------
module light_pattern_sequencer #(
    parameter int NUM_STYLES  = lps_pkg::NUM_STYLES_DEF,
    parameter int PATTERN_LEN = lps_pkg::PATTERN_LEN_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // request side
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [lps_pkg::KIND_W-1:0]            i_kind,
    input  logic [lps_pkg::STYLE_W-1:0]           i_style_index,
    input  logic [lps_pkg::POS_W-1:0]             i_position,
    input  logic [lps_pkg::LETTER_W-1:0]          i_letter,
    input  logic [lps_pkg::LEN_W-1:0]             i_pattern_length,
    input  logic [lps_pkg::TIME_W-1:0]            i_time_ms,
    // result side
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [lps_pkg::STYLE_W-1:0]           o_style_out,
    output logic signed [lps_pkg::LEVEL_W-1:0]    o_level,
    output logic signed [lps_pkg::WHITE_W-1:0]    o_white_level,
    output logic                                  o_last
);

    import lps_pkg::*;

    localparam int SW        = (NUM_STYLES > 1) ? $clog2(NUM_STYLES) : 1;
    localparam int PAT_DEPTH = NUM_STYLES * PATTERN_LEN;
    localparam int AW        = $clog2(PAT_DEPTH);

    // State
    t_state                     r_state, n_state;
    logic [SW-1:0]              r_style;
    logic [STEP_W-1:0]          r_step;
    logic [STEP_W-1:0]          r_last_step;
    logic                       r_step_vld;
    logic [NUM_STYLES-1:0]      r_len_vld;
    logic signed [LEVEL_W-1:0]  r_level;

    logic                       r_out_valid;
    logic [STYLE_W-1:0]         r_out_style;
    logic signed [LEVEL_W-1:0]  r_out_level;
    logic signed [WHITE_W-1:0]  r_out_white;
    logic                       r_out_last;

    // Request decode
    t_kind                      in_kind;
    logic                       in_acc;
    logic                       style_ok;
    logic                       pos_ok;
    logic [LEN_W-1:0]           len_sat;

    // Step from time
    logic [TIME_W-3:0]          st_quarter;
    logic [57:0]                st_prod;
    logic [STEP_W-1:0]          step_calc;

    // Divider
    logic                       div_start;
    logic [STEP_W-1:0]          div_dividend;
    logic [DIVR_W-1:0]          div_divisor;
    t_div_stat                  div_stat;
    logic [DIVR_W-1:0]          div_rem;

    // Memories
    logic                       len_we;
    logic [LEN_W-1:0]           len_rdata;
    logic                       pat_we;
    logic [AW-1:0]              pat_waddr;
    logic [AW-1:0]              pat_raddr;
    logic [LETTER_W-1:0]        pat_rdata;

    // Control conditions
    logic                       step_same;
    logic                       step_take;
    logic                       len_zero;
    logic                       out_free;
    logic                       out_load;
    logic                       style_end;
    logic                       level_full;
    logic                       level_pat;

    // Level arithmetic
    logic [LETTER_W-1:0]        lv_dist;
    logic                       lv_neg;
    logic [13:0]                lv_x;
    logic [28:0]                lv_prod;
    logic [LEVEL_W-1:0]         lv_mag;
    logic signed [LEVEL_W-1:0]  lv_calc;
    logic signed [WHITE_W-1:0]  white_ext;

    assign in_kind   = t_kind'(i_kind);
    assign o_stall   = (r_state != ST_IDLE);
    assign in_acc    = i_valid && !o_stall;
    assign style_ok  = (7'(i_style_index) < 7'(NUM_STYLES));
    assign pos_ok    = (9'(i_position) < 9'(PATTERN_LEN));
    assign len_sat   = (9'(i_pattern_length) > 9'(PATTERN_LEN)) ? LEN_W'(PATTERN_LEN)
                                                                 : i_pattern_length;

    // Step = time / 100 = (time / 4) / 25 by reciprocal multiply
    assign st_quarter = i_time_ms[TIME_W-1:2];
    assign st_prod    = 58'(st_quarter) * 58'(STEP_RECIP);
    assign step_calc  = st_prod[STEP_SH+STEP_W-1:STEP_SH];

    // Memory writes come only from idle-time requests
    assign len_we    = in_acc && (in_kind == KIND_LENGTH) && style_ok;
    assign pat_we    = in_acc && (in_kind == KIND_LETTER) && style_ok && pos_ok;
    assign pat_waddr = AW'(AW'(i_style_index[SW-1:0]) * AW'(PATTERN_LEN)
                           + AW'(i_position));
    assign pat_raddr = AW'(AW'(r_style) * AW'(PATTERN_LEN) + AW'(div_rem));

    lps_ram #(
        .WIDTH (LEN_W),
        .DEPTH (NUM_STYLES)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (i_style_index[SW-1:0]),
        .i_wdata (len_sat),
        .i_raddr (r_style),
        .o_rdata (len_rdata)
    );

    lps_ram #(
        .WIDTH (LETTER_W),
        .DEPTH (PAT_DEPTH)
    ) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (pat_we),
        .i_waddr (pat_waddr),
        .i_wdata (i_letter),
        .i_raddr (pat_raddr),
        .o_rdata (pat_rdata)
    );

    lps_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_stat      (div_stat),
        .o_remainder (div_rem)
    );

    // Conditions shared by next-state and output logic
    assign step_same = r_step_vld && (r_step == r_last_step);
    assign len_zero  = !r_len_vld[r_style] || (len_rdata == '0);
    assign out_free  = !r_out_valid || !i_stall;
    assign style_end = (r_style == SW'(NUM_STYLES - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && (in_kind == KIND_TIME)) n_state = ST_STEP_CHK;
            end
            ST_STEP_CHK: n_state = step_same ? ST_IDLE : ST_LEN_RD;
            ST_LEN_RD:  n_state = ST_LEN_CHK;
            ST_LEN_CHK: n_state = len_zero ? ST_EMIT : ST_MOD_DIV;
            ST_MOD_DIV: begin
                if (div_stat.done) n_state = ST_PAT_RD;
            end
            ST_PAT_RD:  n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_free) n_state = style_end ? ST_IDLE : ST_LEN_RD;
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        div_start    = (r_state == ST_LEN_CHK) && !len_zero;
        div_dividend = r_last_step;
        div_divisor  = DIVR_W'(len_rdata);
        step_take    = (r_state == ST_STEP_CHK) && !step_same;
        level_full   = (r_state == ST_LEN_CHK) && len_zero;
        level_pat    = (r_state == ST_PAT_RD);
        out_load     = (r_state == ST_EMIT) && out_free;
    end

    // Letter to Q.8 level: +/- round((|letter - 'a'| * 64) / 3)
    always_comb begin
        lv_neg  = (pat_rdata < LETTER_DARK);
        lv_dist = lv_neg ? (LETTER_DARK - pat_rdata) : (pat_rdata - LETTER_DARK);
        lv_x    = {lv_dist, 6'b0} + 14'd1;
        lv_prod = 29'(lv_x) * 29'(RECIP3);
        lv_mag  = lv_prod[RECIP3_SH+LEVEL_W-1:RECIP3_SH];
        lv_calc = lv_neg ? -$signed(lv_mag) : $signed(lv_mag);
    end

    assign white_ext = WHITE_W'(r_level);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_style     <= '0;
            r_step_vld  <= 1'b0;
            r_len_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (len_we) begin
                r_len_vld[i_style_index[SW-1:0]] <= 1'b1;
            end
            if (in_acc && (in_kind == KIND_CLEAR)) begin
                r_len_vld  <= '0;
                r_step_vld <= 1'b0;
            end
            if (step_take) begin
                r_step_vld <= 1'b1;
                r_style    <= '0;
            end else if (out_load && !style_end) begin
                r_style <= r_style + SW'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc && (in_kind == KIND_TIME)) begin
            r_step <= step_calc;
        end
        if (step_take) begin
            r_last_step <= r_step;
        end
        if (level_full) begin
            r_level <= FULL_LEVEL;
        end else if (level_pat) begin
            r_level <= lv_calc;
        end
        if (out_load) begin
            r_out_style <= STYLE_W'(r_style);
            r_out_level <= r_level;
            r_out_white <= (white_ext <<< 1) + white_ext;
            r_out_last  <= style_end;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_style_out   = r_out_style;
    assign o_level       = r_out_level;
    assign o_white_level = r_out_white;
    assign o_last        = r_out_last;

    // The final result of a run belongs to the highest style
    a_last_style: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_style_out == STYLE_W'(NUM_STYLES - 1)))
        else $error("last flag on wrong style");

    // A time request always goes to the step check
    a_time_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (in_kind == KIND_TIME)) |=> (r_state == ST_STEP_CHK))
        else $error("time request did not reach step check");

    // After the step check, the stored step matches the new one
    a_step_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STEP_CHK)
        |=> (r_step_vld && (r_last_step == $past(r_step))))
        else $error("last step not updated");

    // White level is three times the level of the same result
    a_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_white_level
                     == (WHITE_W'(o_level) + WHITE_W'(o_level) + WHITE_W'(o_level))))
        else $error("white level mismatch");

endmodule
